[rtl/core/hhts_pkg.sv]
// Package for the HTML head tag scanner: scan state record, match phase codes,
// result status codes and byte constants.
// Depends on nothing; used by hhts_step and html_head_tag_scanner.
`default_nettype none

package hhts_pkg;

	localparam int unsigned CountWidth = 16;

	localparam logic [CountWidth-1:0] LimitReset = 16'd256;

	// match phase codes
	localparam logic [2:0] PH_LEAD  = 3'd0;
	localparam logic [2:0] PH_H     = 3'd1;
	localparam logic [2:0] PH_HE    = 3'd2;
	localparam logic [2:0] PH_HEA   = 3'd3;
	localparam logic [2:0] PH_HEAD  = 3'd4;
	localparam logic [2:0] PH_TRAIL = 3'd5;
	localparam logic [2:0] PH_ANY   = 3'd6;
	localparam logic [2:0] PH_FAIL  = 3'd7;

	// result status codes
	localparam logic [1:0] ST_SEARCH = 2'd0;
	localparam logic [1:0] ST_INSERT = 2'd1;
	localparam logic [1:0] ST_LIMIT  = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	// bytes of interest
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CaseBit  = 8'h20;

	typedef struct packed {
		logic [CountWidth-1:0] bytes_seen;
		logic                  in_tag;
		logic                  in_double_quote;
		logic                  in_single_quote;
		logic [2:0]            match_phase;
		logic                  finished;
	} scan_state_t;

	localparam scan_state_t ScanClear = '{
		bytes_seen:      '0,
		in_tag:          1'b0,
		in_double_quote: 1'b0,
		in_single_quote: 1'b0,
		match_phase:     PH_LEAD,
		finished:        1'b0
	};

endpackage

`default_nettype wire

[rtl/core/hhts_step.sv]
// Next-state logic of the head tag scanner for one document byte.
// Pure combinational; uses hhts_pkg for the state record and codes.
`default_nettype none

module hhts_step (
	input  wire hhts_pkg::scan_state_t              cur,
	input  wire logic [7:0]                         data_byte,
	input  wire logic                               new_document,
	input  wire logic [hhts_pkg::CountWidth-1:0]    search_limit,
	output hhts_pkg::scan_state_t                   nxt,
	output logic [1:0]                              status,
	output logic [hhts_pkg::CountWidth-1:0]         position
);

	hhts_pkg::scan_state_t st;
	logic                  is_ws;
	logic [7:0]            low_byte;
	logic [2:0]            fed_phase;
	logic                  quoted;

	assign is_ws = (data_byte == hhts_pkg::CH_SPACE) ||
		((data_byte >= hhts_pkg::CH_TAB) && (data_byte <= hhts_pkg::CH_CR));
	assign low_byte = ((data_byte >= hhts_pkg::CH_UP_A) && (data_byte <= hhts_pkg::CH_UP_Z)) ?
		(data_byte | hhts_pkg::CaseBit) : data_byte;

	// clear before handling the byte when a new document starts
	assign st = new_document ? hhts_pkg::ScanClear : cur;
	assign quoted = st.in_double_quote || st.in_single_quote;

	// phase after feeding this byte to the tag content matcher
	always_comb begin
		case (st.match_phase)
			hhts_pkg::PH_LEAD: begin
				fed_phase = is_ws ? hhts_pkg::PH_LEAD :
					((low_byte == hhts_pkg::CH_H) ? hhts_pkg::PH_H : hhts_pkg::PH_FAIL);
			end
			hhts_pkg::PH_H: begin
				fed_phase = (low_byte == hhts_pkg::CH_E) ? hhts_pkg::PH_HE : hhts_pkg::PH_FAIL;
			end
			hhts_pkg::PH_HE: begin
				fed_phase = (low_byte == hhts_pkg::CH_A) ? hhts_pkg::PH_HEA : hhts_pkg::PH_FAIL;
			end
			hhts_pkg::PH_HEA: begin
				fed_phase = (low_byte == hhts_pkg::CH_D) ? hhts_pkg::PH_HEAD : hhts_pkg::PH_FAIL;
			end
			hhts_pkg::PH_HEAD: begin
				fed_phase = is_ws ? hhts_pkg::PH_TRAIL :
					((data_byte == hhts_pkg::CH_NUL) ? hhts_pkg::PH_ANY : hhts_pkg::PH_FAIL);
			end
			hhts_pkg::PH_TRAIL: begin
				fed_phase = is_ws ? hhts_pkg::PH_TRAIL : hhts_pkg::PH_FAIL;
			end
			hhts_pkg::PH_ANY: begin
				fed_phase = hhts_pkg::PH_ANY;
			end
			default: begin
				fed_phase = hhts_pkg::PH_FAIL;
			end
		endcase
	end

	always_comb begin
		nxt = st;
		status = hhts_pkg::ST_SEARCH;
		if (st.finished) begin
			status = hhts_pkg::ST_DONE;
		end else if (st.bytes_seen >= search_limit) begin
			status = hhts_pkg::ST_LIMIT;
		end else begin
			case (data_byte)
				hhts_pkg::CH_LT: begin
					// an unquoted '<' restarts the tag content
					nxt.match_phase = quoted ? fed_phase : hhts_pkg::PH_LEAD;
					nxt.in_tag = 1'b1;
				end
				hhts_pkg::CH_GT: begin
					if (st.in_tag) begin
						if (quoted) begin
							nxt.match_phase = fed_phase;
						end else begin
							nxt.in_tag = 1'b0;
							if ((st.match_phase == hhts_pkg::PH_HEAD) ||
								(st.match_phase == hhts_pkg::PH_TRAIL) ||
								(st.match_phase == hhts_pkg::PH_ANY)) begin
								nxt.finished = 1'b1;
								status = hhts_pkg::ST_INSERT;
							end
						end
					end
				end
				hhts_pkg::CH_DQ: begin
					if (st.in_tag) begin
						if (!st.in_single_quote) begin
							nxt.in_double_quote = !st.in_double_quote;
						end
						nxt.match_phase = fed_phase;
					end
				end
				hhts_pkg::CH_SQ: begin
					if (st.in_tag) begin
						if (!st.in_double_quote) begin
							nxt.in_single_quote = !st.in_single_quote;
						end
						nxt.match_phase = fed_phase;
					end
				end
				default: begin
					if (st.in_tag) begin
						nxt.match_phase = fed_phase;
					end
				end
			endcase
		end
		if (status == hhts_pkg::ST_SEARCH) begin
			nxt.bytes_seen = st.bytes_seen + 1'b1;
		end
	end

	assign position = st.bytes_seen;

endmodule

`default_nettype wire

[rtl/core/html_head_tag_scanner.sv]
// Top level of the HTML head tag scanner: input register, scan state,
// search limit register and result register. Uses hhts_pkg and hhts_step.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    data_byte, new_document
//   out      source     out_valid / out_stall  status, position
//   cfg      sink       cfg_valid / cfg_ready  search_limit
//
// One byte per cycle sustained while the output is not stalled; a byte lands in the
// input register when it is accepted and reaches the result register through the scan step once that register is free.
// The scan state updates as the byte moves into the result register.
// Reset clears scan state and sets the limit to 256. A stalled output holds
// its result while the input register still takes one more request.
`default_nettype none

module html_head_tag_scanner (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            new_document,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [1:0]                           status,
	output logic [hhts_pkg::CountWidth-1:0]      position,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [hhts_pkg::CountWidth-1:0] search_limit
);

	logic                              valid_s1;
	logic [7:0]                        byte_s1;
	logic                              new_doc_s1;
	hhts_pkg::scan_state_t             state_q;
	hhts_pkg::scan_state_t             state_next;
	logic [hhts_pkg::CountWidth-1:0]   limit_q;
	logic                              out_valid_q;
	logic [1:0]                        status_q;
	logic [hhts_pkg::CountWidth-1:0]   position_q;
	logic [1:0]                        step_status;
	logic [hhts_pkg::CountWidth-1:0]   step_position;
	logic                              advance;

	// the result slot is free or being taken this cycle
	assign advance = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	hhts_step u_step (
		.cur          (state_q),
		.data_byte    (byte_s1),
		.new_document (new_doc_s1),
		.search_limit (limit_q),
		.nxt          (state_next),
		.status       (step_status),
		.position     (step_position)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			state_q <= hhts_pkg::ScanClear;
			limit_q <= hhts_pkg::LimitReset;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= search_limit;
			end
			// the input register takes a request whenever it is empty or draining
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					state_q <= state_next;
				end
			end
		end
	end

	// payload registers: load only on a moving request
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			new_doc_s1 <= new_document;
		end
		if (advance && valid_s1) begin
			status_q <= step_status;
			position_q <= step_position;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign position = position_q;

endmodule

`default_nettype wire
